FILE: rtl/nibble_isa_decode_execute_macros.svh
// Assertion macros shared by the nibble instruction executor RTL.
// Depends on a clock named clk and a reset named rst in the using module.
`ifndef NIBBLE_ISA_DECODE_EXECUTE_MACROS_SVH
`define NIBBLE_ISA_DECODE_EXECUTE_MACROS_SVH

// Checked on every rising edge except while reset is held.
`define NIDE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define NIDE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/nide_pkg.sv
// Shared constants and types for the nibble instruction executor.
// No dependencies; imported by nide_ram and nibble_isa_decode_execute.
`default_nettype none

package nide_pkg;

  // Register file geometry and default datapath width.
  localparam int REG_COUNT      = 16;
  localparam int IDX_W          = 4;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int OUT_VALUE_W    = 32;

  // Opcodes.
  localparam logic [3:0] OP_LDI  = 4'h1;
  localparam logic [3:0] OP_SWAP = 4'h2;
  localparam logic [3:0] OP_ADD  = 4'h3;
  localparam logic [3:0] OP_SUB  = 4'h4;
  localparam logic [3:0] OP_MUL  = 4'h5;
  localparam logic [3:0] OP_DIV  = 4'h6;
  localparam logic [3:0] OP_NOP  = 4'hA;
  localparam logic [3:0] OP_SYS  = 4'hF;

  // Operand nibble that selects a bus write under the system opcode.
  localparam logic [3:0] BUS_MARK = 4'hC;

  // Halt status codes.
  localparam logic [1:0] HALT_RUN     = 2'd0;
  localparam logic [1:0] HALT_INSTR   = 2'd1;
  localparam logic [1:0] HALT_DIVZERO = 2'd2;
  localparam logic [1:0] HALT_ALREADY = 2'd3;

  // One result beat.
  typedef struct packed {
    logic                   reg_written;
    logic [IDX_W-1:0]       reg_index;
    logic [OUT_VALUE_W-1:0] reg_value;
    logic                   second_written;
    logic [IDX_W-1:0]       second_index;
    logic [OUT_VALUE_W-1:0] second_value;
    logic                   bus_write;
    logic [3:0]             bus_device;
    logic [3:0]             bus_address;
    logic [15:0]            bus_data;
    logic [1:0]             halt_status;
    logic                   unknown_opcode;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/nide_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nide_pkg for its default geometry.
`default_nettype none

module nide_ram
  import nide_pkg::*;
#(
  parameter int WIDTH = DATA_WIDTH_DEF,
  parameter int DEPTH = REG_COUNT
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/nibble_isa_decode_execute.sv
// Nibble instruction executor: decode, sequencer, shared adder and register file.
// Depends on nide_pkg, nide_ram and nibble_isa_decode_execute_macros.svh.
//
// Usage: one instruction word enters per beat on the input channel
// (instruction, in_valid, in_ready), and exactly one result beat leaves on
// the output channel (out_valid, out_ready and the result fields).
// The block works on one instruction at a time; in_ready is high only while
// the sequencer is idle. Operands come from the register file RAM one read
// per cycle (three reads), then the instruction executes on one shared
// adder/subtractor. No-op, bus write, halt, unknown opcode and divide by
// zero go from execute straight to the result; load immediate, add and
// subtract then write one register, and swap writes one or two. Multiply
// and divide first run one shift-add or restoring step a cycle on the
// shared adder. Any instruction after a halt skips the reads and execute.
// The next input beat is taken the cycle after a result is loaded into the
// output register. If the receiver stalls, the next instruction runs to
// completion and waits. Reset clears the register file (through
// per-register valid bits), the halted flag and both channels.
`default_nettype none

`include "nibble_isa_decode_execute_macros.svh"

module nibble_isa_decode_execute
  import nide_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [31:0]            instruction,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        reg_written,
  output logic [IDX_W-1:0]            reg_index,
  output logic [OUT_VALUE_W-1:0]      reg_value,
  output logic                        second_written,
  output logic [IDX_W-1:0]            second_index,
  output logic [OUT_VALUE_W-1:0]      second_value,
  output logic                        bus_write,
  output logic [3:0]                  bus_device,
  output logic [3:0]                  bus_address,
  output logic [15:0]                 bus_data,
  output logic [1:0]                  halt_status,
  output logic                        unknown_opcode
);

  localparam int W  = DATA_WIDTH;
  localparam int AW = DATA_WIDTH + 1;
  localparam int CW = $clog2(DATA_WIDTH);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD_A = 9'b000000010,
    S_RD_B = 9'b000000100,
    S_RD_C = 9'b000001000,
    S_EXEC = 9'b000010000,
    S_STEP = 9'b000100000,
    S_WR1  = 9'b001000000,
    S_WR2  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [31:0]          instr;
  logic                 halted;
  logic [REG_COUNT-1:0] valid_bits;
  logic                 rd_valid;
  logic [W-1:0]         opa, opb, opc;
  logic [W-1:0]         work_acc;
  logic [CW-1:0]        cnt;
  res_t                 res;
  res_t                 out_res;

  logic [3:0] op, r1, r2, r3, u1, u2, x1, x2;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [W-1:0]     ram_wdata, ram_rdata, rd_data;

  logic [AW-1:0] add_x, add_y;
  logic          add_sub;
  logic [AW:0]   add_sum;
  logic          no_borrow;

  logic [W-1:0] imm_val;
  logic [W-1:0] wval;

  // Operand nibbles of the held instruction.
  assign op = instr[31:28];
  assign r1 = instr[27:24];
  assign r2 = instr[23:20];
  assign r3 = instr[19:16];
  assign u1 = instr[15:12];
  assign u2 = instr[11:8];
  assign x1 = instr[7:4];
  assign x2 = instr[3:0];

  assign in_ready = (state == S_IDLE);

  // Register file storage; an entry never written since reset reads as zero.
  nide_ram #(
    .WIDTH(W),
    .DEPTH(REG_COUNT)
  ) u_regfile (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_data = rd_valid ? ram_rdata : '0;

  // Read address follows the operand fetch order: r2, r3, then r1.
  always_comb begin
    unique case (state)
      S_RD_A:  ram_raddr = r2;
      S_RD_B:  ram_raddr = r3;
      default: ram_raddr = r1;
    endcase
  end

  // Shared adder: operand add/subtract, multiply accumulate, divide trial subtract.
  always_comb begin
    add_x   = {1'b0, opa};
    add_y   = {1'b0, opb};
    add_sub = (op == OP_SUB);
    if (state == S_STEP) begin
      if (op == OP_DIV) begin
        add_x   = {work_acc, opa[W-1]};
        add_y   = {1'b0, opb};
        add_sub = 1'b1;
      end else begin
        add_x   = {1'b0, work_acc};
        add_y   = {1'b0, opa};
        add_sub = 1'b0;
      end
    end
  end

  assign add_sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                   + {{AW{1'b0}}, add_sub};
  assign no_borrow = add_sum[AW];

  // Load-immediate value: u1 alone when u2 is zero.
  assign imm_val = (u2 != 4'h0) ? W'({u1, u2}) : W'({4'h0, u1});

  // Value for the first register write.
  always_comb begin
    case (op) inside
      OP_LDI:          wval = imm_val;
      OP_ADD, OP_SUB:  wval = add_sum[W-1:0];
      OP_MUL:          wval = work_acc;
      default:         wval = opa;
    endcase
  end

  // Register file write port.
  assign ram_we    = (state == S_WR1) || (state == S_WR2);
  assign ram_waddr = (state == S_WR2) ? r2 : r1;
  assign ram_wdata = (state == S_WR2) ? opc : wval;

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = halted ? S_DONE : S_RD_A;
        end
      end
      S_RD_A: state_next = S_RD_B;
      S_RD_B: state_next = S_RD_C;
      S_RD_C: state_next = S_EXEC;
      S_EXEC: begin
        case (op) inside
          OP_LDI, OP_SWAP, OP_ADD, OP_SUB: state_next = S_WR1;
          OP_MUL:                          state_next = S_STEP;
          OP_DIV:  state_next = (opb == '0) ? S_DONE : S_STEP;
          default:                         state_next = S_DONE;
        endcase
      end
      S_STEP: begin
        if (cnt == '0) begin
          state_next = S_WR1;
        end
      end
      S_WR1: state_next = ((op == OP_SWAP) && (r1 != r2)) ? S_WR2 : S_DONE;
      S_WR2: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      halted     <= 1'b0;
      valid_bits <= '0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= valid_bits[ram_raddr];
      if (ram_we) begin
        valid_bits[ram_waddr] <= 1'b1;
      end
      if (state == S_EXEC && op == OP_SYS && instr[27:0] == '1) begin
        halted <= 1'b1;
      end
      if (state == S_EXEC && op == OP_DIV && opb == '0) begin
        halted <= 1'b1;
      end
      // A new result beat replaces a drained one in the same cycle.
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          instr <= instruction;
          if (halted) begin
            res <= '{halt_status: HALT_ALREADY, default: '0};
          end else begin
            res <= '0;
          end
        end
      end
      S_RD_A: ;
      S_RD_B: opa <= rd_data;
      S_RD_C: opb <= rd_data;
      S_EXEC: begin
        opc      <= rd_data;
        work_acc <= '0;
        cnt      <= CW'(W - 1);
        case (op) inside
          OP_NOP, OP_LDI, OP_SWAP, OP_ADD, OP_SUB, OP_MUL: ;
          OP_DIV: begin
            if (opb == '0) begin
              res.halt_status <= HALT_DIVZERO;
            end
          end
          OP_SYS: begin
            if (instr[27:0] == '1) begin
              res.halt_status <= HALT_INSTR;
            end else if (x2 == BUS_MARK) begin
              res.bus_write   <= 1'b1;
              res.bus_device  <= r1;
              res.bus_address <= r2;
              res.bus_data    <= {r3, u1, u2, x1};
            end
          end
          default: res.unknown_opcode <= 1'b1;
        endcase
      end
      S_STEP: begin
        cnt <= cnt - CW'(1);
        if (op == OP_DIV) begin
          // Restoring divide: quotient shifts through opa, remainder in work_acc.
          if (no_borrow) begin
            work_acc <= add_sum[W-1:0];
            opa      <= {opa[W-2:0], 1'b1};
          end else begin
            work_acc <= {work_acc[W-2:0], opa[W-1]};
            opa      <= {opa[W-2:0], 1'b0};
          end
        end else begin
          // Shift-add multiply: multiplicand in opa, multiplier in opb.
          if (opb[0]) begin
            work_acc <= add_sum[W-1:0];
          end
          opa <= {opa[W-2:0], 1'b0};
          opb <= {1'b0, opb[W-1:1]};
        end
      end
      S_WR1: begin
        res.reg_written <= 1'b1;
        res.reg_index   <= r1;
        res.reg_value   <= OUT_VALUE_W'(wval);
      end
      S_WR2: begin
        res.second_written <= 1'b1;
        res.second_index   <= r2;
        res.second_value   <= OUT_VALUE_W'(opc);
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_res <= res;
        end
      end
      default: ;
    endcase
  end

  // Result ports.
  assign reg_written    = out_res.reg_written;
  assign reg_index      = out_res.reg_index;
  assign reg_value      = out_res.reg_value;
  assign second_written = out_res.second_written;
  assign second_index   = out_res.second_index;
  assign second_value   = out_res.second_value;
  assign bus_write      = out_res.bus_write;
  assign bus_device     = out_res.bus_device;
  assign bus_address    = out_res.bus_address;
  assign bus_data       = out_res.bus_data;
  assign halt_status    = out_res.halt_status;
  assign unknown_opcode = out_res.unknown_opcode;

  // The halted flag is sticky until reset.
  `NIDE_ASSERT(a_halt_sticky, halted |=> halted, "halted flag cleared without reset")

  // A reported halt always leaves the block halted.
  `NIDE_ASSERT(a_halt_reported, (out_valid && (halt_status == HALT_INSTR || halt_status == HALT_DIVZERO)) |-> halted, "halt reported but block not halted")

  // A register write never comes with a bus write or a halt.
  `NIDE_ASSERT(a_write_excl, (out_valid && reg_written) |-> (!bus_write && halt_status == HALT_RUN), "register write mixed with bus write or halt")

  // A second write belongs to a swap of two distinct registers.
  `NIDE_ASSERT(a_swap_pair, (out_valid && second_written) |-> (reg_written && reg_index != second_index), "second write without a distinct first write")

  // Output beat is empty and the input is ready right after reset.
  `NIDE_ASSERT_ALWAYS(a_reset_empty, rst |=> (!out_valid && in_ready), "channels not cleared by reset")

endmodule

`default_nettype wire
